// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("port property violated");

// Next-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("port property violated");

`endif

// File: rtl/grr_pkg.sv
// ----------------------------------------------------------------------------
// grr_pkg
// Types and constants shared by the glyph row run rasterizer modules.
// ----------------------------------------------------------------------------
package grr_pkg;

    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 16;
    localparam int RECT_W     = 13;
    localparam int SCALE_W    = 8;
    localparam int DIM_W      = 5;
    localparam int ROW_BITS_W = 24;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 80;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;

    // Register map, index = paddr[4:2].
    typedef enum logic [2:0] {
        REG_INK_COLOR    = 3'd0,
        REG_PAPER_COLOR  = 3'd1,
        REG_SCALE        = 3'd2,
        REG_GLYPH_WIDTH  = 3'd3,
        REG_GLYPH_HEIGHT = 3'd4
    } reg_idx_t;

    localparam logic [COLOR_W-1:0] INK_COLOR_RST    = 16'hFFFF;
    localparam logic [COLOR_W-1:0] PAPER_COLOR_RST  = 16'h0000;
    localparam logic [SCALE_W-1:0] SCALE_RST        = 8'd1;
    localparam logic [DIM_W-1:0]   GLYPH_WIDTH_RST  = 5'd16;
    localparam logic [DIM_W-1:0]   GLYPH_HEIGHT_RST = 5'd16;

    // Kind of rectangle the back end is about to send.
    typedef enum logic [1:0] {
        OP_BG      = 2'd0,
        OP_OUTLINE = 2'd1,
        OP_RUN     = 2'd2
    } op_kind_t;

    typedef struct packed {
        logic [COLOR_W-1:0] ink_color;
        logic [COLOR_W-1:0] paper_color;
        logic [SCALE_W-1:0] scale;
        logic [DIM_W-1:0]   glyph_width;
        logic [DIM_W-1:0]   glyph_height;
    } cfg_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] ry;
        logic [SCALE_W-1:0] s;
        logic [RECT_W-1:0]  bg_w;
        logic [RECT_W-1:0]  bg_h;
        logic               need_bg;
        logic               need_out;
    } cmd_hdr_t;

endpackage

// File: rtl/glyph_row_run_rasterizer.sv
// ----------------------------------------------------------------------------
// glyph_row_run_rasterizer
// Turns glyph bitmap rows into filled and outline rectangle commands.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Protocol      Beat contents
//   s_axis    in         valid/ready   one glyph row (tuser = mode)
//   m_axis    out        valid/ready   one rectangle (tuser = outline, tlast)
//   APB       in/out     psel/penable  five configuration registers
//
// The front end classifies a row in the cycle it is taken and pushes it into
// a two-entry queue; rows that draw nothing are dropped there.
// The back end loads a command and then emits its rectangles one at a time,
// at most 13 per row (background plus up to twelve runs) with the default
// 24-column mask. The first beat passes through the queue, the command
// registers, the operation and result registers. Reset is synchronous
// and active low; it empties the queue and the output stages.
// A stalled m_axis fills the operation and result registers, then the queue,
// and only then deasserts s_axis_tready.
module glyph_row_run_rasterizer import grr_pkg::*; #(
    parameter int MAX_GLYPH_WIDTH = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input row stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: x_origin[15:0], y_origin[31:16], row_index[36:32], row_bits[60:37]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: mode[0]
    input  logic [0:0]            s_axis_tuser,
    // Rectangle command stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: rect_x[15:0], rect_y[31:16], rect_w[44:32], rect_h[57:45],
    //        rect_color[73:58]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // tuser: outline_only[0]
    output logic [0:0]            m_axis_tuser,
    output logic                  m_axis_tlast,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int QW = $bits(cmd_hdr_t) + MAX_GLYPH_WIDTH;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_wr;

    cmd_hdr_t                   f_hdr, b_hdr;
    logic [MAX_GLYPH_WIDTH-1:0] f_mask, b_mask;
    logic                       f_valid, f_ready, b_valid, b_ready;
    logic [QW-1:0]              b_data;

    logic [COORD_W-1:0] out_x, out_y;
    logic [RECT_W-1:0]  out_w, out_h;
    logic [COLOR_W-1:0] out_color;
    logic               out_outline;

    // Register file. The word index is the byte address divided by four.
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ink_color    <= INK_COLOR_RST;
            cfg_reg.paper_color  <= PAPER_COLOR_RST;
            cfg_reg.scale        <= SCALE_RST;
            cfg_reg.glyph_width  <= GLYPH_WIDTH_RST;
            cfg_reg.glyph_height <= GLYPH_HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_INK_COLOR:    cfg_reg.ink_color    <= pwdata[COLOR_W-1:0];
                REG_PAPER_COLOR:  cfg_reg.paper_color  <= pwdata[COLOR_W-1:0];
                REG_SCALE:        cfg_reg.scale        <= pwdata[SCALE_W-1:0];
                REG_GLYPH_WIDTH:  cfg_reg.glyph_width  <= pwdata[DIM_W-1:0];
                REG_GLYPH_HEIGHT: cfg_reg.glyph_height <= pwdata[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_INK_COLOR:    prdata = {{(APB_DATA_W-COLOR_W){1'b0}}, cfg_reg.ink_color};
            REG_PAPER_COLOR:  prdata = {{(APB_DATA_W-COLOR_W){1'b0}}, cfg_reg.paper_color};
            REG_SCALE:        prdata = {{(APB_DATA_W-SCALE_W){1'b0}}, cfg_reg.scale};
            REG_GLYPH_WIDTH:  prdata = {{(APB_DATA_W-DIM_W){1'b0}}, cfg_reg.glyph_width};
            REG_GLYPH_HEIGHT: prdata = {{(APB_DATA_W-DIM_W){1'b0}}, cfg_reg.glyph_height};
            default:          prdata = '0;
        endcase
    end

    grr_front #(
        .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH)
    ) u_front (
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_mode  (s_axis_tuser[0]),
        .in_x     (s_axis_tdata[15:0]),
        .in_y     (s_axis_tdata[31:16]),
        .in_row   (s_axis_tdata[36:32]),
        .in_bits  (s_axis_tdata[60:37]),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_hdr    (f_hdr),
        .q_mask   (f_mask)
    );

    grr_queue #(
        .WIDTH(QW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_hdr, f_mask}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    assign b_hdr  = b_data[QW-1:MAX_GLYPH_WIDTH];
    assign b_mask = b_data[MAX_GLYPH_WIDTH-1:0];

    grr_back #(
        .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (b_valid),
        .q_ready   (b_ready),
        .q_hdr     (b_hdr),
        .q_mask    (b_mask),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_x       (out_x),
        .m_y       (out_y),
        .m_w       (out_w),
        .m_h       (out_h),
        .m_color   (out_color),
        .m_outline (out_outline),
        .m_last    (m_axis_tlast)
    );

    // Pack the rectangle fields, lowest field first, zero filled to 80 bits.
    assign m_axis_tdata = {6'b0, out_color, out_h, out_w, out_y, out_x};
    assign m_axis_tuser = out_outline;

endmodule

// File: rtl/grr_queue.sv
// ----------------------------------------------------------------------------
// grr_queue
// Short first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
module grr_queue import grr_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/grr_front.sv
// ----------------------------------------------------------------------------
// grr_front
// Classifies an incoming row: clamps the glyph size, builds the column mask,
// precomputes scaled sizes and drops items that produce no rectangles.
// ----------------------------------------------------------------------------
module grr_front import grr_pkg::*; #(
    parameter int MAX_GLYPH_WIDTH = 24
) (
    input  cfg_t                       cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_mode,
    input  logic [COORD_W-1:0]         in_x,
    input  logic [COORD_W-1:0]         in_y,
    input  logic [DIM_W-1:0]           in_row,
    input  logic [ROW_BITS_W-1:0]      in_bits,
    output logic                       q_valid,
    input  logic                       q_ready,
    output cmd_hdr_t                   q_hdr,
    output logic [MAX_GLYPH_WIDTH-1:0] q_mask
);

    localparam logic [DIM_W:0] MAX_DIM = (DIM_W + 1)'(MAX_GLYPH_WIDTH);

    logic [SCALE_W-1:0]         s_eff;
    logic [DIM_W-1:0]           w_clamp;
    logic [DIM_W-1:0]           h_clamp;
    logic [RECT_W-1:0]          row_off;
    logic [MAX_GLYPH_WIDTH-1:0] col_mask;
    logic                       run_en;
    logic                       need_bg;
    logic                       keep;

    assign s_eff   = (cfg.scale == '0) ? SCALE_W'(1) : cfg.scale;
    assign w_clamp = ({1'b0, cfg.glyph_width} > MAX_DIM) ? MAX_DIM[DIM_W-1:0]
                                                         : cfg.glyph_width;
    assign h_clamp = ({1'b0, cfg.glyph_height} > MAX_DIM) ? MAX_DIM[DIM_W-1:0]
                                                          : cfg.glyph_height;

    // Column c of the mask is pixel c of the row; columns past the row bits
    // or past the glyph width read as clear.
    for (genvar c = 0; c < MAX_GLYPH_WIDTH; c++) begin : g_col
        if (c < ROW_BITS_W) begin : g_in
            assign col_mask[c] = in_bits[ROW_BITS_W-1-c] &&
                                 ((DIM_W + 1)'(c) < {1'b0, w_clamp});
        end else begin : g_out
            assign col_mask[c] = 1'b0;
        end
    end

    assign run_en  = !in_mode && (in_row < h_clamp);
    assign need_bg = in_mode || (in_row == '0);
    assign q_mask  = run_en ? col_mask : '0;
    assign keep    = need_bg || (q_mask != '0);

    assign row_off = {{(RECT_W-DIM_W){1'b0}}, in_row} * {{(RECT_W-SCALE_W){1'b0}}, s_eff};

    assign q_hdr.x0       = in_x;
    assign q_hdr.y0       = in_y;
    assign q_hdr.ry       = in_y + {{(COORD_W-RECT_W){1'b0}}, row_off};
    assign q_hdr.s        = s_eff;
    assign q_hdr.bg_w     = {{(RECT_W-DIM_W){1'b0}}, w_clamp} *
                            {{(RECT_W-SCALE_W){1'b0}}, s_eff};
    assign q_hdr.bg_h     = {{(RECT_W-DIM_W){1'b0}}, h_clamp} *
                            {{(RECT_W-SCALE_W){1'b0}}, s_eff};
    assign q_hdr.need_bg  = need_bg;
    assign q_hdr.need_out = in_mode;

    // Items with nothing to draw are taken and discarded here.
    assign q_valid  = in_valid && keep;
    assign in_ready = q_ready;

endmodule

// File: rtl/grr_back.sv
// ----------------------------------------------------------------------------
// grr_back
// Walks one command at a time: background, outline, then one run per cycle
// unless m_ready stalls it, through an operation register and a result register.
// ----------------------------------------------------------------------------
module grr_back import grr_pkg::*; #(
    parameter int MAX_GLYPH_WIDTH = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cfg_t                       cfg,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  cmd_hdr_t                   q_hdr,
    input  logic [MAX_GLYPH_WIDTH-1:0] q_mask,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [COORD_W-1:0]         m_x,
    output logic [COORD_W-1:0]         m_y,
    output logic [RECT_W-1:0]          m_w,
    output logic [RECT_W-1:0]          m_h,
    output logic [COLOR_W-1:0]         m_color,
    output logic                       m_outline,
    output logic                       m_last
);

    localparam int MW = MAX_GLYPH_WIDTH;
    localparam int LW = $clog2(MAX_GLYPH_WIDTH + 1);
    localparam int PW = LW + SCALE_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic            st_reg, st_next;
    cmd_hdr_t        cur_hdr_reg, cur_hdr_next;
    logic [MW-1:0]   mask_reg, mask_next;
    logic            need_bg_reg, need_bg_next;
    logic            need_out_reg, need_out_next;

    logic            op_valid_reg, op_valid_next;
    op_kind_t        op_kind_reg, op_kind_next;
    logic [LW-1:0]   op_start_reg, op_start_next;
    logic [LW-1:0]   op_len_reg, op_len_next;
    logic            op_last_reg, op_last_next;
    cmd_hdr_t        op_hdr_reg;

    logic            m_valid_reg, m_valid_next;
    logic [COORD_W-1:0] m_x_reg, m_y_reg;
    logic [RECT_W-1:0]  m_w_reg, m_h_reg;
    logic [COLOR_W-1:0] m_color_reg;
    logic            m_outline_reg, m_last_reg;

    logic [MW-1:0]   lsb;
    logic [MW:0]     carry_sum;
    logic [MW-1:0]   mask_after;
    logic [LW-1:0]   run_lo, run_hi;
    logic            out_load, emit;

    logic [PW-1:0]      off_prod, len_prod;
    logic [COORD_W-1:0] rx, ry;
    logic [RECT_W-1:0]  rw, rh;
    logic [COLOR_W-1:0] rcolor;
    logic               routline;

    // Run extraction: the lowest set bit starts the run; adding it ripples
    // through the run and lands on the first clear column after it.
    assign lsb        = mask_reg & (~mask_reg + 1'b1);
    assign carry_sum  = {1'b0, mask_reg} + {1'b0, lsb};
    assign mask_after = mask_reg & carry_sum[MW-1:0];

    always_comb begin
        run_lo = '0;
        for (int i = MW - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                run_lo = LW'(i);
            end
        end
    end

    always_comb begin
        run_hi = '0;
        for (int i = MW; i >= 0; i--) begin
            if (carry_sum[i]) begin
                run_hi = LW'(i);
            end
        end
    end

    assign out_load = op_valid_reg && (!m_valid_reg || m_ready);
    assign emit     = (st_reg == ST_EMIT) && (!op_valid_reg || out_load);
    assign q_ready  = (st_reg == ST_IDLE);

    always_comb begin
        st_next       = st_reg;
        cur_hdr_next  = cur_hdr_reg;
        mask_next     = mask_reg;
        need_bg_next  = need_bg_reg;
        need_out_next = need_out_reg;
        op_kind_next  = op_kind_reg;
        op_start_next = op_start_reg;
        op_len_next   = op_len_reg;
        op_last_next  = op_last_reg;
        op_valid_next = op_valid_reg;
        if (out_load) begin
            op_valid_next = 1'b0;
        end
        unique case (st_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cur_hdr_next  = q_hdr;
                    mask_next     = q_mask;
                    need_bg_next  = q_hdr.need_bg;
                    need_out_next = q_hdr.need_out;
                    st_next       = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit) begin
                    op_valid_next = 1'b1;
                    priority if (need_bg_reg) begin
                        op_kind_next = OP_BG;
                        op_last_next = !need_out_reg && (mask_reg == '0);
                        need_bg_next = 1'b0;
                    end else if (need_out_reg) begin
                        op_kind_next  = OP_OUTLINE;
                        op_last_next  = (mask_reg == '0);
                        need_out_next = 1'b0;
                    end else begin
                        op_kind_next  = OP_RUN;
                        op_start_next = run_lo;
                        op_len_next   = run_hi - run_lo;
                        op_last_next  = (mask_after == '0);
                        mask_next     = mask_after;
                    end
                    if (op_last_next) begin
                        st_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // Result computation from the operation register.
    assign off_prod = {{SCALE_W{1'b0}}, op_start_reg} * {{LW{1'b0}}, op_hdr_reg.s};
    assign len_prod = {{SCALE_W{1'b0}}, op_len_reg} * {{LW{1'b0}}, op_hdr_reg.s};

    always_comb begin
        rx       = op_hdr_reg.x0;
        ry       = op_hdr_reg.y0;
        rw       = op_hdr_reg.bg_w;
        rh       = op_hdr_reg.bg_h;
        rcolor   = cfg.paper_color;
        routline = 1'b0;
        unique case (op_kind_reg)
            OP_BG: begin
                rcolor = cfg.paper_color;
            end
            OP_OUTLINE: begin
                rcolor   = cfg.ink_color;
                routline = 1'b1;
            end
            OP_RUN: begin
                rx     = op_hdr_reg.x0 + COORD_W'(off_prod);
                ry     = op_hdr_reg.ry;
                rw     = RECT_W'(len_prod);
                rh     = {{(RECT_W-SCALE_W){1'b0}}, op_hdr_reg.s};
                rcolor = cfg.ink_color;
            end
            default: begin
                rcolor = cfg.paper_color;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            op_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            need_bg_reg  <= 1'b0;
            need_out_reg <= 1'b0;
            mask_reg     <= '0;
        end else begin
            st_reg       <= st_next;
            op_valid_reg <= op_valid_next;
            m_valid_reg  <= m_valid_next;
            need_bg_reg  <= need_bg_next;
            need_out_reg <= need_out_next;
            mask_reg     <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_hdr_reg  <= cur_hdr_next;
        op_kind_reg  <= op_kind_next;
        op_start_reg <= op_start_next;
        op_len_reg   <= op_len_next;
        op_last_reg  <= op_last_next;
        if (emit) begin
            op_hdr_reg <= cur_hdr_reg;
        end
        if (out_load) begin
            m_x_reg       <= rx;
            m_y_reg       <= ry;
            m_w_reg       <= rw;
            m_h_reg       <= rh;
            m_color_reg   <= rcolor;
            m_outline_reg <= routline;
            m_last_reg    <= op_last_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_x       = m_x_reg;
    assign m_y       = m_y_reg;
    assign m_w       = m_w_reg;
    assign m_h       = m_h_reg;
    assign m_color   = m_color_reg;
    assign m_outline = m_outline_reg;
    assign m_last    = m_last_reg;

endmodule

// File: rtl/grr_checker.sv
// ----------------------------------------------------------------------------
// grr_checker
// Port-level properties of the glyph row run rasterizer, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grr_checker import grr_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 psel,
    input logic                 pready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]           m_axis_tuser,
    input logic                 m_axis_tlast
);

    // A stalled rectangle beat keeps its contents.
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // The outline of a missing glyph is always the final beat of its item.
    `ASSERT_IMP(a_outline_last, aclk, aresetn, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)

    // Nothing is offered in the first cycle after reset.
    `ASSERT_IMP(a_reset_quiet, aclk, aresetn, !$past(aresetn), !m_axis_tvalid)

    // The register port never inserts wait states.
    `ASSERT_IMP(a_no_wait, aclk, aresetn, psel, pready)

endmodule

bind glyph_row_run_rasterizer grr_checker u_grr_checker (.*);
